>>> src/krt_pkg.sv
// Package for the keyed record table: table sizing, operation and status codes,
// sequencer states and output field helpers. No dependencies.
`default_nettype none

package krt_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam int KEY_W   = 20;
   localparam int VALUE_W = 32;
   localparam int POS_W   = 4;
   localparam int COUNT_W = 5;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_DELETE = 2'd1,
      OP_UPDATE = 2'd2,
      OP_LOOKUP = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_DUP     = 2'd1,
      STAT_FULL    = 2'd2,
      STAT_MISSING = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EXEC,
      ST_SHIFT,
      ST_RESP
   } state_type;

   // Low bits of a table index, zero-extended for narrow tables.
   function automatic logic [POS_W-1:0] to_position(input logic [IDX_W-1:0] idx);
      logic [IDX_W+POS_W-1:0] wide;
      wide = {{POS_W{1'b0}}, idx};
      return wide[POS_W-1:0];
   endfunction

   // Low bits of the entry count, zero-extended for narrow tables.
   function automatic logic [COUNT_W-1:0] to_count(input logic [CNT_W-1:0] cnt);
      logic [CNT_W+COUNT_W-1:0] wide;
      wide = {{COUNT_W{1'b0}}, cnt};
      return wide[COUNT_W-1:0];
   endfunction

endpackage

`default_nettype wire

>>> src/keyed_record_table_core.sv
// Keyed record table core: ordered key/payload table with add, delete, update
// and lookup, run by a small sequencer over one memory write port and one read port. Uses krt_pkg.
//
//   channel   dir   handshake              payload
//   req       in    req_tvalid/req_tready  tuser: kind; tdata: entry_key, entry_value
//   rsp       out   rsp_tvalid/rsp_tready  tuser: status; tdata: found_value,
//                                          position, entry_count
//
// Sequence: one word at a time. A word is accepted, the held entries are scanned
// through the registered memory read port until the key matches, the operation
// executes, a delete then shifts later entries down, and the result waits in the
// result register. The single read port of the key/payload memory sets the pace:
// one entry per cycle.
// Reset: synchronous, active high; empties the table (fill count zero). The
// memory is not cleared: entries at or above the fill count are never used.
// Stalls: req_tready is high only while idle; a result holds in its register
// until rsp_tready takes it.
`default_nettype none

module keyed_record_table_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [55:0] req_tdata,   // [19:0] entry_key, [51:20] entry_value, rest zero
   input  wire logic [1:0]  req_tuser,   // [1:0] kind
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // [31:0] found_value, [35:32] position,
                                         // [40:36] entry_count, rest zero
   output logic [1:0]       rsp_tuser    // [1:0] status
);

   localparam int AW = krt_pkg::IDX_W;
   localparam int CW = krt_pkg::CNT_W;
   localparam int KW = krt_pkg::KEY_W;
   localparam int VW = krt_pkg::VALUE_W;

   // Key and payload memory: one write and one registered read per cycle.
   logic [KW-1:0] key_mem [krt_pkg::TABLE_DEPTH];
   logic [VW-1:0] val_mem [krt_pkg::TABLE_DEPTH];

   krt_pkg::state_type  state_ff, state_in;
   krt_pkg::op_type     kind_ff, kind_in;
   krt_pkg::status_type status_ff, status_in;

   logic [KW-1:0] key_ff, key_in;
   logic [VW-1:0] value_ff, value_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] scan_ff, scan_in;      // next address to read
   logic          pend_ff, pend_in;      // read data register holds a live entry
   logic [AW-1:0] pend_idx_ff, pend_idx_in;
   logic          hit_ff, hit_in;
   logic [AW-1:0] hit_idx_ff, hit_idx_in;
   logic [VW-1:0] found_ff, found_in;
   logic [krt_pkg::POS_W-1:0] pos_ff, pos_in;

   logic [KW-1:0] rd_key_ff;
   logic [VW-1:0] rd_val_ff;
   logic [AW-1:0] rd_addr;
   logic          mem_we;
   logic [AW-1:0] wr_addr;
   logic [KW-1:0] wr_key;
   logic [VW-1:0] wr_val;

   // Memory: write port and registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem[wr_addr] <= wr_key;
         val_mem[wr_addr] <= wr_val;
      end
      rd_key_ff <= key_mem[rd_addr];
      rd_val_ff <= val_mem[rd_addr];
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= krt_pkg::ST_IDLE;
         fill_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         pend_ff  <= pend_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      key_ff      <= key_in;
      value_ff    <= value_in;
      scan_ff     <= scan_in;
      pend_idx_ff <= pend_idx_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      found_ff    <= found_in;
      pos_ff      <= pos_in;
      status_ff   <= status_in;
   end

   // Sequencer: next state, memory port control and result fields.
   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      key_in      = key_ff;
      value_in    = value_ff;
      fill_in     = fill_ff;
      scan_in     = scan_ff;
      pend_in     = pend_ff;
      pend_idx_in = pend_idx_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      found_in    = found_ff;
      pos_in      = pos_ff;
      status_in   = status_ff;
      rd_addr     = scan_ff[AW-1:0];
      mem_we      = 1'b0;
      wr_addr     = hit_idx_ff;
      wr_key      = key_ff;
      wr_val      = value_ff;

      unique case (state_ff)
         krt_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               kind_in  = krt_pkg::op_type'(req_tuser[1:0]);
               key_in   = req_tdata[KW-1:0];
               value_in = req_tdata[KW+VW-1:KW];
               scan_in  = '0;
               pend_in  = 1'b0;
               hit_in   = 1'b0;
               state_in = krt_pkg::ST_SCAN;
            end
         end

         krt_pkg::ST_SCAN: begin
            // Compare last cycle's read while issuing the next one.
            if (pend_ff && rd_key_ff == key_ff) begin
               hit_in     = 1'b1;
               hit_idx_in = pend_idx_ff;
               found_in   = rd_val_ff;
               pend_in    = 1'b0;
               state_in   = krt_pkg::ST_EXEC;
            end else if (scan_ff < fill_ff) begin
               pend_in     = 1'b1;
               pend_idx_in = scan_ff[AW-1:0];
               scan_in     = scan_ff + CW'(1);
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = krt_pkg::ST_EXEC;
               end
            end
         end

         krt_pkg::ST_EXEC: begin
            found_in  = '0;
            status_in = krt_pkg::STAT_OK;
            pos_in    = '0;
            state_in  = krt_pkg::ST_RESP;
            if (kind_ff == krt_pkg::OP_ADD) begin
               priority if (hit_ff) begin
                  status_in = krt_pkg::STAT_DUP;
                  pos_in    = krt_pkg::to_position(hit_idx_ff);
               end else if (fill_ff == CW'(krt_pkg::TABLE_DEPTH)) begin
                  status_in = krt_pkg::STAT_FULL;
               end else begin
                  // Append at the end.
                  mem_we  = 1'b1;
                  wr_addr = fill_ff[AW-1:0];
                  pos_in  = krt_pkg::to_position(fill_ff[AW-1:0]);
                  fill_in = fill_ff + CW'(1);
               end
            end else if (!hit_ff) begin
               status_in = krt_pkg::STAT_MISSING;
            end else begin
               pos_in = krt_pkg::to_position(hit_idx_ff);
               unique case (kind_ff)
                  krt_pkg::OP_DELETE: begin
                     // Start compaction at the entry after the removed one.
                     scan_in  = CW'(hit_idx_ff) + CW'(1);
                     pend_in  = 1'b0;
                     state_in = krt_pkg::ST_SHIFT;
                  end
                  krt_pkg::OP_UPDATE: begin
                     mem_we = 1'b1;
                  end
                  krt_pkg::OP_LOOKUP: begin
                     found_in = found_ff;
                  end
                  default: begin
                     status_in = krt_pkg::STAT_OK;
                  end
               endcase
            end
         end

         krt_pkg::ST_SHIFT: begin
            // Write the entry read last cycle one place down.
            if (pend_ff) begin
               mem_we  = 1'b1;
               wr_addr = pend_idx_ff - AW'(1);
               wr_key  = rd_key_ff;
               wr_val  = rd_val_ff;
            end
            if (scan_ff < fill_ff) begin
               pend_in     = 1'b1;
               pend_idx_in = scan_ff[AW-1:0];
               scan_in     = scan_ff + CW'(1);
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  fill_in  = fill_ff - CW'(1);
                  state_in = krt_pkg::ST_RESP;
               end
            end
         end

         krt_pkg::ST_RESP: begin
            if (rsp_tready) begin
               state_in = krt_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = krt_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_tready = (state_ff == krt_pkg::ST_IDLE);
   assign rsp_tvalid = (state_ff == krt_pkg::ST_RESP);
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {7'd0, krt_pkg::to_count(fill_ff), pos_ff, found_ff};

endmodule

`default_nettype wire

>>> src/krt_check.sv
// Port-level checker for keyed_record_table_core, bound into that module.
// Depends on keyed_record_table_core's port list only.
`default_nettype none

module krt_check (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser
);

   // Hold a stalled result word.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed or dropped while stalled");

   // Never take a new word while a result is pending.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request taken while result pending");

   // Drop ready after taking a word.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready stayed high after accepting a word");

   // One result per word: no repeat after delivery.
   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready |=> !rsp_tvalid)
      else $error("result repeated after delivery");

endmodule

bind keyed_record_table_core krt_check u_krt_check (.*);

`default_nettype wire

>>> test/tb.sv
// Self-checking bench for keyed_record_table_core: directed table walk, then random traffic.
// Holds its own table predictor for the expected words. Depends on krt_pkg and the core.
`timescale 1ns / 1ps

module tb;

   localparam int TABLE_DEPTH = krt_pkg::TABLE_DEPTH;
   localparam int KEY_W       = krt_pkg::KEY_W;
   localparam int VALUE_W     = krt_pkg::VALUE_W;
   localparam int POS_W       = krt_pkg::POS_W;
   localparam int COUNT_W     = krt_pkg::COUNT_W;

   localparam int RANDOM_ITEMS = 400;
   localparam int QUIET_ITEMS  = 60;    // final stretch with no idling on either side
   localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
   localparam int STALL_LIMIT  = 3000;  // cycles with no accepted or delivered word before giving up
   localparam int DRAIN_CYCLES = 60;
   localparam int POOL_SIZE    = 24;

   typedef struct {
      krt_pkg::status_type status;
      logic [VALUE_W-1:0]  found_value;
      logic [POS_W-1:0]    position;
      logic [COUNT_W-1:0]  entry_count;
   } reply_type;

   typedef struct {
      krt_pkg::op_type    kind;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
      bit                 typed;   // reply written out below instead of predicted
      reply_type          reply;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;    // [19:0] entry_key, [51:20] entry_value, rest zero
   logic [1:0]  req_tuser = '0;    // [1:0] kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;         // [31:0] found_value, [35:32] position,
                                   // [40:36] entry_count, rest zero
   logic [1:0]  rsp_tuser;         // [1:0] status

   // predictor state: the table as it should stand after every accepted word
   logic [KEY_W-1:0]   model_keys   [TABLE_DEPTH];
   logic [VALUE_W-1:0] model_values [TABLE_DEPTH];
   int                 model_fill = 0;

   reply_type   pending_replies[$];
   row_type     directed[$];
   int          error_count  = 0;
   int          stall_cycles = 0;
   bit          quiet_tail   = 1'b0;
   bit          long_hold_due = 1'b0;

   keyed_record_table_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 0;
   end

   // Apply one operation to the predicted table and return the reply it must produce.
   // The duplicate check comes before the full check on add.
   function automatic reply_type apply_table_op(krt_pkg::op_type kind,
                                                logic [KEY_W-1:0] key,
                                                logic [VALUE_W-1:0] value);
      reply_type r;
      int hit;
      int slot;
      int i;
      hit  = -1;
      slot = 0;
      r.status      = krt_pkg::STAT_OK;
      r.found_value = '0;
      for (i = 0; i < model_fill; i++)
         if (hit < 0 && model_keys[i] == key) hit = i;
      if (kind == krt_pkg::OP_ADD) begin
         if (hit >= 0) begin
            r.status = krt_pkg::STAT_DUP;
            slot = hit;
         end else if (model_fill >= TABLE_DEPTH) begin
            r.status = krt_pkg::STAT_FULL;
         end else begin
            model_keys[model_fill]   = key;
            model_values[model_fill] = value;
            slot = model_fill;
            model_fill++;
         end
      end else if (hit < 0) begin
         r.status = krt_pkg::STAT_MISSING;
      end else begin
         slot = hit;
         case (kind)
            krt_pkg::OP_DELETE: begin
               // close the gap so insertion order survives
               for (i = hit; i + 1 < model_fill; i++) begin
                  model_keys[i]   = model_keys[i + 1];
                  model_values[i] = model_values[i + 1];
               end
               model_fill--;
            end
            krt_pkg::OP_UPDATE: model_values[hit] = value;
            default:            r.found_value = model_values[hit];
         endcase
      end
      r.position    = POS_W'(slot);
      r.entry_count = COUNT_W'(model_fill);
      return r;
   endfunction

   // Offer one request word after an optional gap; hold it until the core takes it.
   // Called and returning at a rising edge, so tvalid never drops and rises in one step.
   task automatic offer_word(krt_pkg::op_type kind, logic [KEY_W-1:0] key,
                             logic [VALUE_W-1:0] value, int gap, bit typed,
                             reply_type want);
      reply_type predicted;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'b0, value, key};
      // inputs and core outputs are settled at the falling edge: decide the handshake there
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      predicted = apply_table_op(kind, key, value);
      pending_replies.push_back(typed ? want : predicted);
      @(posedge clock);
   endtask

   // Receiver: random short holds, one long hold-off on request, none in the tail.
   initial begin
      int hold_left;
      bit long_hold_done;
      hold_left = 0;
      long_hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_due && !long_hold_done) begin
            long_hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!quiet_tail && !reset && $urandom_range(0, 5) == 0) begin
            hold_left = $urandom_range(1, 12) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !reset;
         end
      end
   end

   // Result checker and progress counter, sampled where nothing is changing.
   always @(negedge clock) begin
      reply_type want;
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (rsp_tvalid && rsp_tready) begin
         if (pending_replies.size() == 0) begin
            $error("unexpected result word: tuser %0d tdata %h", rsp_tuser, rsp_tdata);
            error_count++;
         end else begin
            want = pending_replies.pop_front();
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata[31:0] !== want.found_value) begin
               $error("found_value: expected %h, actual %h", want.found_value, rsp_tdata[31:0]);
               error_count++;
            end
            if (rsp_tdata[35:32] !== want.position) begin
               $error("position: expected %0d, actual %0d", want.position, rsp_tdata[35:32]);
               error_count++;
            end
            if (rsp_tdata[40:36] !== want.entry_count) begin
               $error("entry_count: expected %0d, actual %0d", want.entry_count,
                      rsp_tdata[40:36]);
               error_count++;
            end
            if (rsp_tdata[47:41] !== '0) begin
               $error("tdata padding: expected 0, actual %h", rsp_tdata[47:41]);
               error_count++;
            end
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   initial begin
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("tb: failure");
      $finish;
   end

   initial begin
      logic [KEY_W-1:0]   key_pool [POOL_SIZE];
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
      reply_type          none;
      krt_pkg::op_type    kind;
      int                 pick;
      int                 gap;
      int                 n;

      none = '{krt_pkg::STAT_OK, '0, '0, '0};

      // empty table: every keyed operation misses
      directed.push_back('{krt_pkg::OP_LOOKUP, 20'd0, 32'd0, 1,
                           '{krt_pkg::STAT_MISSING, 32'd0, 4'd0, 5'd0}});
      directed.push_back('{krt_pkg::OP_DELETE, 20'd5, 32'd0, 1,
                           '{krt_pkg::STAT_MISSING, 32'd0, 4'd0, 5'd0}});
      directed.push_back('{krt_pkg::OP_UPDATE, 20'd5, 32'hFFFF_FFFF, 1,
                           '{krt_pkg::STAT_MISSING, 32'd0, 4'd0, 5'd0}});
      // extremes of key and payload; the top key is the largest 20-bit value
      directed.push_back('{krt_pkg::OP_ADD, 20'd0, 32'd0, 1,
                           '{krt_pkg::STAT_OK, 32'd0, 4'd0, 5'd1}});
      directed.push_back('{krt_pkg::OP_ADD, 20'hFFFFF, 32'hFFFF_FFFF, 1,
                           '{krt_pkg::STAT_OK, 32'd0, 4'd1, 5'd2}});
      directed.push_back('{krt_pkg::OP_ADD, 20'd0, 32'h1234_5678, 1,
                           '{krt_pkg::STAT_DUP, 32'd0, 4'd0, 5'd2}});
      directed.push_back('{krt_pkg::OP_LOOKUP, 20'hFFFFF, 32'd0, 1,
                           '{krt_pkg::STAT_OK, 32'hFFFF_FFFF, 4'd1, 5'd2}});
      directed.push_back('{krt_pkg::OP_UPDATE, 20'hFFFFF, 32'h5A5A_A5A5, 1,
                           '{krt_pkg::STAT_OK, 32'd0, 4'd1, 5'd2}});
      // fill to the top; replies come from the predictor
      for (n = 2; n < TABLE_DEPTH; n++)
         directed.push_back('{krt_pkg::OP_ADD, KEY_W'(n * 65537), $urandom, 0, none});
      // full table: new key is refused, a present key still reports duplicate
      directed.push_back('{krt_pkg::OP_ADD, 20'd999999, 32'd7, 1,
                           '{krt_pkg::STAT_FULL, 32'd0, 4'd0, 5'd16}});
      directed.push_back('{krt_pkg::OP_ADD, 20'd0, 32'd7, 1,
                           '{krt_pkg::STAT_DUP, 32'd0, 4'd0, 5'd16}});
      // delete the head: everything behind it shifts down
      directed.push_back('{krt_pkg::OP_DELETE, 20'd0, 32'd0, 1,
                           '{krt_pkg::STAT_OK, 32'd0, 4'd0, 5'd15}});

      key_pool[0] = '0;
      key_pool[1] = '1;
      for (n = 2; n < POOL_SIZE; n++) key_pool[n] = KEY_W'($urandom);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i])
         offer_word(directed[i].kind, directed[i].key, directed[i].value,
                    0, directed[i].typed, directed[i].reply);

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet_tail = 1'b1;
         if (n == 100) long_hold_due = 1'b1;
         // alternate add-heavy and delete-heavy stretches to swing between full and empty
         pick = $urandom_range(0, 99);
         if ((n / 50) % 2 == 0) begin
            if (pick < 50)      kind = krt_pkg::OP_ADD;
            else if (pick < 65) kind = krt_pkg::OP_DELETE;
            else if (pick < 80) kind = krt_pkg::OP_UPDATE;
            else                kind = krt_pkg::OP_LOOKUP;
         end else begin
            if (pick < 20)      kind = krt_pkg::OP_ADD;
            else if (pick < 60) kind = krt_pkg::OP_DELETE;
            else if (pick < 75) kind = krt_pkg::OP_UPDATE;
            else                kind = krt_pkg::OP_LOOKUP;
         end
         key   = $urandom_range(0, 9) < 7 ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                          : KEY_W'($urandom);
         value = $urandom;
         gap   = (!quiet_tail && $urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : 0;
         offer_word(kind, key, value, gap, 1'b0, none);
      end
      req_tvalid <= 1'b0;

      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && pending_replies.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

>>> files.f
src/krt_pkg.sv
src/keyed_record_table_core.sv
src/krt_check.sv
test/tb.sv
